// ===== src/buddy_heap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// buddy heap allocator assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BUDDY_HEAP_ALLOCATOR_DEFINES_SVH
`define BUDDY_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define BHA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BHA_ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BHA_ASSERT(name, clk, rst, prop, msg)
`define BHA_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif
`endif

// ===== src/bha_pkg.sv =====
// ----------------------------------------------------------------------------
// bha_pkg
// shared types, constants and helpers of the buddy heap allocator
// ----------------------------------------------------------------------------
package bha_pkg;

   localparam int MAX_UNITS_LOG2  = 10;
   localparam int UNIT_BYTES_LOG2 = 4;
   localparam int UNIT_W          = MAX_UNITS_LOG2;
   localparam int POS_W           = MAX_UNITS_LOG2 + 1;
   localparam int DEPTH           = 1 << MAX_UNITS_LOG2;
   localparam int SZ_W            = 4;
   localparam int OFF_W           = 14;
   localparam int BYTES_W         = 16;
   localparam int UNITS_W         = BYTES_W - UNIT_BYTES_LOG2 + 1;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_REALLOC = 2'd2;

   localparam logic [SZ_W-1:0] HL_RESET = SZ_W'(MAX_UNITS_LOG2);

   typedef struct packed {
      logic [1:0]         req_type;
      logic [BYTES_W-1:0] req_bytes;
      logic               has_block;
      logic [OFF_W-1:0]   block_offset;
   } bha_req_type;

   typedef struct packed {
      logic             status;
      logic [OFF_W-1:0] payload_offset;
      logic [OFF_W-1:0] copy_bytes;
   } bha_rsp_type;

   typedef struct packed {
      logic [SZ_W-1:0] size_log2;
      logic            free;
   } bha_entry_type;

   typedef struct packed {
      logic              en;
      logic [UNIT_W-1:0] addr;
      bha_entry_type     data;
   } bha_wr_type;

   // log2 of units needed for the payload plus one header unit
   function automatic logic [SZ_W-1:0] need_log2(input logic [BYTES_W-1:0] bytes);
      logic [UNITS_W-1:0] m1;
      logic [SZ_W-1:0]    k;
      m1 = UNITS_W'(((BYTES_W + 1)'(bytes) + (BYTES_W + 1)'((1 << UNIT_BYTES_LOG2) - 1))
           >> UNIT_BYTES_LOG2);
      k = '0;
      for (int i = 0; i < UNITS_W; i++) begin
         if (m1[i]) begin
            k = SZ_W'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

// ===== src/bha_ram.sv =====
// ----------------------------------------------------------------------------
// bha_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bha_ctrl.sv =====
// ----------------------------------------------------------------------------
// bha_ctrl
// request sequencer: header walk, scan and merge passes, splitting, with one
// shared next-block adder and compare
// ----------------------------------------------------------------------------
`include "buddy_heap_allocator_defines.svh"

module bha_ctrl
   import bha_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [SZ_W-1:0] hl,
   input  logic            cfg_wr,
   input  logic            start,
   input  bha_req_type     req_data,
   output logic            busy,
   output logic            rsp_valid,
   output bha_rsp_type     rsp_data,
   output bha_wr_type      ram_wr,
   output logic [UNIT_W-1:0] ram_raddr,
   input  bha_entry_type   ram_rdata
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_AS_RD, S_AS_USE, S_SC_RD0, S_SC_USE0, S_SC_RDB, S_SC_USEB,
      S_SC_RDR, S_SC_USER, S_END, S_SP_CHK, S_SP_LO, S_SP_HI, S_MARK, S_FREE_OLD,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic              has_ff, has_in;
   logic [SZ_W-1:0]   k_ff, k_in;
   logic [UNIT_W-1:0] u_ff, u_in;
   logic [SZ_W-1:0]   us_ff, us_in;
   logic [POS_W-1:0]  r_ff, r_in;
   logic [POS_W-1:0]  b_ff, b_in;
   logic [SZ_W-1:0]   rs_ff, rs_in;
   logic              rf_ff, rf_in;
   logic [UNIT_W-1:0] best_ff, best_in;
   logic              bv_ff, bv_in;
   logic [SZ_W-1:0]   bsz_ff, bsz_in;
   logic              merge_ff, merge_in;
   logic              retry_ff, retry_in;
   logic              chg_ff, chg_in;
   bha_rsp_type       rsp_ff, rsp_in;

   logic [POS_W-1:0]  heap_end;
   logic [POS_W-1:0]  add_base;
   logic [SZ_W-1:0]   add_sz;
   logic [POS_W-1:0]  add_sum;
   logic              add_lt;
   logic [UNIT_W-1:0] dec_unit;

   assign heap_end = POS_W'(1) << hl;
   assign dec_unit = req_data.block_offset[OFF_W-1:UNIT_BYTES_LOG2] - UNIT_W'(1);

   // shared next-block unit
   always_comb begin
      add_base = (state_ff == S_SC_USEB) ? b_ff : r_ff;
      add_sz   = (state_ff == S_SP_LO || state_ff == S_SP_HI) ? rs_ff - SZ_W'(1)
                                                              : ram_rdata.size_log2;
      add_sum  = add_base + (POS_W'(1) << add_sz);
      add_lt   = add_sum < heap_end;
   end

   always_comb begin
      logic [SZ_W-1:0]   ns;
      logic              bv1;
      logic [UNIT_W-1:0] b1;
      logic [SZ_W-1:0]   bs1;
      logic [UNIT_W-1:0] inc_u;
      logic [UNIT_W:0]   cp;

      state_in = state_ff;
      op_in    = op_ff;
      has_in   = has_ff;
      k_in     = k_ff;
      u_in     = u_ff;
      us_in    = us_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      rs_in    = rs_ff;
      rf_in    = rf_ff;
      best_in  = best_ff;
      bv_in    = bv_ff;
      bsz_in   = bsz_ff;
      merge_in = merge_ff;
      retry_in = retry_ff;
      chg_in   = chg_ff;
      rsp_in   = rsp_ff;
      ram_wr   = '0;
      ram_raddr = r_ff[UNIT_W-1:0];
      ns    = rs_ff + SZ_W'(1);
      bv1   = bv_ff;
      b1    = best_ff;
      bs1   = bsz_ff;
      inc_u = r_ff[UNIT_W-1:0] + UNIT_W'(1);
      cp    = (UNIT_W + 1)'((POS_W'(1) << us_ff) - POS_W'(1));

      unique case (state_ff)
         S_INIT: begin
            ram_wr.en             = 1'b1;
            ram_wr.addr           = '0;
            ram_wr.data.size_log2 = hl;
            ram_wr.data.free      = 1'b1;
            state_in              = S_IDLE;
         end
         S_IDLE: begin
            if (cfg_wr) begin
               state_in = S_INIT;
            end else if (start) begin
               op_in    = req_data.req_type;
               has_in   = req_data.has_block;
               k_in     = need_log2(req_data.req_bytes);
               u_in     = dec_unit;
               rsp_in   = '0;
               r_in     = '0;
               merge_in = 1'b0;
               retry_in = 1'b0;
               priority if (req_data.req_type == REQ_FREE) begin
                  state_in = (req_data.has_block && {1'b0, dec_unit} < heap_end)
                             ? S_AS_RD : S_DONE;
               end else if (req_data.req_type == REQ_ALLOC ||
                            (req_data.req_type == REQ_REALLOC && !req_data.has_block)) begin
                  state_in = S_SC_RD0;
               end else if (req_data.req_type == REQ_REALLOC) begin
                  if ({1'b0, dec_unit} < heap_end) begin
                     state_in = S_AS_RD;
                  end else begin
                     rsp_in.status = 1'b1;
                     state_in      = S_DONE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_AS_RD: begin
            state_in = S_AS_USE;
         end
         S_AS_USE: begin
            if (r_ff == {1'b0, u_ff}) begin
               us_in = ram_rdata.size_log2;
               if (ram_rdata.free) begin
                  rsp_in.status = (op_ff == REQ_REALLOC);
                  state_in      = S_DONE;
               end else if (op_ff == REQ_FREE) begin
                  state_in = S_FREE_OLD;
               end else if (k_ff <= ram_rdata.size_log2) begin
                  rsp_in.payload_offset = {u_ff + UNIT_W'(1), UNIT_BYTES_LOG2'(0)};
                  state_in              = S_DONE;
               end else begin
                  r_in     = '0;
                  state_in = S_SC_RD0;
               end
            end else begin
               r_in = add_sum;
               if (add_lt) begin
                  state_in = S_AS_RD;
               end else begin
                  rsp_in.status = (op_ff == REQ_REALLOC);
                  state_in      = S_DONE;
               end
            end
         end
         S_SC_RD0: begin
            ram_raddr = '0;
            state_in  = S_SC_USE0;
         end
         S_SC_USE0: begin
            rs_in  = ram_rdata.size_log2;
            rf_in  = ram_rdata.free;
            b_in   = add_sum;
            chg_in = 1'b0;
            bv_in  = 1'b0;
            if (add_lt) begin
               state_in = S_SC_RDB;
            end else begin
               best_in  = '0;
               bsz_in   = ram_rdata.size_log2;
               bv_in    = !merge_ff && ram_rdata.free && (k_ff <= ram_rdata.size_log2);
               state_in = S_END;
            end
         end
         S_SC_RDB: begin
            ram_raddr = b_ff[UNIT_W-1:0];
            state_in  = S_SC_USEB;
         end
         S_SC_USEB: begin
            if (rf_ff && ram_rdata.free && rs_ff == ram_rdata.size_log2) begin
               ram_wr.en             = 1'b1;
               ram_wr.addr           = r_ff[UNIT_W-1:0];
               ram_wr.data.size_log2 = ns;
               ram_wr.data.free      = 1'b1;
               chg_in                = 1'b1;
               if (!merge_ff) begin
                  if (k_ff <= ns && (!bv_ff || best_ff == r_ff[UNIT_W-1:0] ||
                                     ns <= bsz_ff)) begin
                     best_in = r_ff[UNIT_W-1:0];
                     bsz_in  = ns;
                     bv_in   = 1'b1;
                  end else if (bv_ff && best_ff == r_ff[UNIT_W-1:0]) begin
                     bsz_in = ns;
                  end
               end
               r_in     = add_sum;
               state_in = add_lt ? S_SC_RDR : S_END;
            end else begin
               if (!merge_ff && rf_ff && k_ff <= rs_ff && (!bv1 || rs_ff <= bs1)) begin
                  bv1 = 1'b1;
                  b1  = r_ff[UNIT_W-1:0];
                  bs1 = rs_ff;
               end
               if (!merge_ff && ram_rdata.free && k_ff <= ram_rdata.size_log2 &&
                   (!bv1 || ram_rdata.size_log2 <= bs1)) begin
                  bv1 = 1'b1;
                  b1  = b_ff[UNIT_W-1:0];
                  bs1 = ram_rdata.size_log2;
               end
               bv_in   = bv1;
               best_in = b1;
               bsz_in  = bs1;
               if (rs_ff > ram_rdata.size_log2) begin
                  r_in     = b_ff;
                  rs_in    = ram_rdata.size_log2;
                  rf_in    = ram_rdata.free;
                  b_in     = add_sum;
                  state_in = add_lt ? S_SC_RDB : S_END;
               end else begin
                  r_in     = add_sum;
                  state_in = add_lt ? S_SC_RDR : S_END;
               end
            end
         end
         S_SC_RDR: begin
            state_in = S_SC_USER;
         end
         S_SC_USER: begin
            rs_in    = ram_rdata.size_log2;
            rf_in    = ram_rdata.free;
            b_in     = add_sum;
            state_in = add_lt ? S_SC_RDB : S_END;
         end
         S_END: begin
            r_in = '0;
            if (merge_ff) begin
               if (!chg_ff) begin
                  merge_in = 1'b0;
                  retry_in = 1'b1;
               end
               state_in = S_SC_RD0;
            end else if (bv_ff) begin
               r_in     = {1'b0, best_ff};
               rs_in    = bsz_ff;
               state_in = S_SP_CHK;
            end else if (retry_ff) begin
               rsp_in.status = 1'b1;
               state_in      = S_DONE;
            end else begin
               merge_in = 1'b1;
               state_in = S_SC_RD0;
            end
         end
         S_SP_CHK: begin
            state_in = (rs_ff > k_ff) ? S_SP_LO : S_MARK;
         end
         S_SP_LO: begin
            ram_wr.en             = 1'b1;
            ram_wr.addr           = r_ff[UNIT_W-1:0];
            ram_wr.data.size_log2 = add_sz;
            ram_wr.data.free      = 1'b1;
            state_in              = S_SP_HI;
         end
         S_SP_HI: begin
            ram_wr.en             = 1'b1;
            ram_wr.addr           = add_sum[UNIT_W-1:0];
            ram_wr.data.size_log2 = add_sz;
            ram_wr.data.free      = 1'b1;
            r_in                  = add_sum;
            rs_in                 = add_sz;
            state_in              = S_SP_CHK;
         end
         S_MARK: begin
            ram_wr.en             = 1'b1;
            ram_wr.addr           = r_ff[UNIT_W-1:0];
            ram_wr.data.size_log2 = rs_ff;
            ram_wr.data.free      = 1'b0;
            rsp_in.payload_offset = {inc_u, UNIT_BYTES_LOG2'(0)};
            if (op_ff == REQ_REALLOC && has_ff) begin
               rsp_in.copy_bytes = {cp[UNIT_W-1:0], UNIT_BYTES_LOG2'(0)};
               state_in          = S_FREE_OLD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_OLD: begin
            ram_wr.en             = 1'b1;
            ram_wr.addr           = u_ff;
            ram_wr.data.size_log2 = us_ff;
            ram_wr.data.free      = 1'b1;
            state_in              = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         merge_ff <= 1'b0;
         retry_ff <= 1'b0;
         chg_ff   <= 1'b0;
         bv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         merge_ff <= merge_in;
         retry_ff <= retry_in;
         chg_ff   <= chg_in;
         bv_ff    <= bv_in;
      end
      op_ff   <= op_in;
      has_ff  <= has_in;
      k_ff    <= k_in;
      u_ff    <= u_in;
      us_ff   <= us_in;
      r_ff    <= r_in;
      b_ff    <= b_in;
      rs_ff   <= rs_in;
      rf_ff   <= rf_in;
      best_ff <= best_in;
      bsz_ff  <= bsz_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = rsp_ff;

   `BHA_ASSERT(a_done_then_idle, clock, reset, rsp_valid |=> !busy, "no idle after result")
   `BHA_ASSERT(a_accept_busy, clock, reset, (start && !busy && !cfg_wr) |=> busy, "request lost")
   `BHA_ASSERT(a_fail_zero, clock, reset, (rsp_valid && rsp_data.status) |-> (rsp_data.payload_offset == '0 && rsp_data.copy_bytes == '0), "failure with data")
   `BHA_ASSERT(a_copy_realloc, clock, reset, (rsp_valid && rsp_data.copy_bytes != '0) |-> (op_ff == REQ_REALLOC), "copy on non realloc")
   `BHA_ASSERT_NEVER(a_no_idle_write, clock, reset, (ram_wr.en && state_ff == S_IDLE), "header write while idle")

endmodule

// ===== src/buddy_heap_allocator.sv =====
// Each header visited is read through the one read port of the header ram; a failed scan
// adds merge passes and a second scan, and each halving of the chosen block checks its size
// and then writes the low and the high half headers.
// Throughput: one request at a time; busy stays high through the result strobe cycle.
// Reset, and a heap size write taken while idle, write the single free header.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// buddy_heap_allocator
// buddy allocator over a power-of-two heap, with csr port and header ram
// ----------------------------------------------------------------------------
module buddy_heap_allocator
   import bha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bha_req_type req_data,
   output logic        rsp_valid,
   output bha_rsp_type rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [SZ_W-1:0] hl_ff, hl_in;
   logic            cfg_wr;
   bha_wr_type      ram_wr;
   logic [UNIT_W-1:0] ram_raddr;
   bha_entry_type   ram_rdata;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = {(32 - SZ_W)'(0), hl_ff};

   // clamp heap size into the supported range
   always_comb begin
      hl_in = hl_ff;
      if (cfg_wr) begin
         priority if (csr_pwdata[SZ_W-1:0] == '0) begin
            hl_in = SZ_W'(1);
         end else if (csr_pwdata[SZ_W-1:0] > HL_RESET) begin
            hl_in = HL_RESET;
         end else begin
            hl_in = csr_pwdata[SZ_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff <= HL_RESET;
      end else begin
         hl_ff <= hl_in;
      end
   end

   bha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .hl        (hl_ff),
      .cfg_wr    (cfg_wr),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ram_wr    (ram_wr),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   bha_ram #(
      .WIDTH ($bits(bha_entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// ===== bench/buddy_heap_allocator_test.sv =====
// ----------------------------------------------------------------------------
// buddy_heap_allocator_test
// self-checking bench: directed table then random allocate, free and
// reallocate traffic over several heap sizes, checked against a local
// model of the header scan, lazy merges and halving
// ----------------------------------------------------------------------------
module buddy_heap_allocator_test
   import bha_pkg::*;
();

   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam logic [2:0] ADDR_HEAP_LOG2 = 3'd0;
   localparam int NO_UNIT = -1;
   localparam int UMASK = DEPTH - 1;
   localparam int WATCHDOG = 100000;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] bytes;
      logic        has;
      logic [13:0] off;
      bit          typed;
      bha_rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   bha_req_type req_data;
   logic        rsp_valid;
   bha_rsp_type rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [3:0]  hdr_size [DEPTH];
   bit          hdr_free [DEPTH];
   int          heap_log2;
   logic [13:0] live_q [$];
   bha_rsp_type rsp_q [$];
   int          errors;
   int          gap_pct;
   int          idle_cycles;

   buddy_heap_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int hsz(int u);
      return int'(hdr_size[u & UMASK]);
   endfunction

   function automatic int next_blk(int u);
      return u + (1 << hsz(u));
   endfunction

   function automatic void rebuild_heap(int v);
      heap_log2 = v;
      foreach (hdr_size[i]) begin
         hdr_size[i] = '0;
         hdr_free[i] = 1'b0;
      end
      hdr_size[0] = 4'(v);
      hdr_free[0] = 1'b1;
   endfunction

   function automatic int halve_to(int u, int k);
      int s;
      while (hsz(u) > k) begin
         s = hsz(u) - 1;
         hdr_size[u & UMASK] = 4'(s);
         u = next_blk(u);
         hdr_size[u & UMASK] = 4'(s);
         hdr_free[u & UMASK] = 1'b1;
      end
      return hsz(u) >= k ? u : NO_UNIT;
   endfunction

   function automatic bit fits_better(int s, int k, int best);
      return k <= s && (best == NO_UNIT || s <= hsz(best));
   endfunction

   function automatic int find_block(int k);
      int h, r, b, best, rs, bs;
      h = 1 << heap_log2;
      r = 0;
      b = next_blk(0);
      best = NO_UNIT;
      if (b == h && hdr_free[0]) return halve_to(0, k);
      while (r < h && b < h) begin
         if (hdr_free[r & UMASK] && hdr_free[b & UMASK] && hsz(r) == hsz(b)) begin
            hdr_size[r & UMASK] = 4'(hsz(r) + 1);
            if (fits_better(hsz(r), k, best)) best = r;
            r = next_blk(b);
            if (r < h) b = next_blk(r);
         end else begin
            rs = hsz(r);
            bs = hsz(b);
            if (hdr_free[r & UMASK] && fits_better(rs, k, best)) best = r;
            if (hdr_free[b & UMASK] && fits_better(bs, k, best)) best = b;
            if (rs > bs) begin
               r = b;
               b = next_blk(b);
            end else begin
               r = next_blk(b);
               if (r < h) b = next_blk(r);
            end
         end
      end
      return best == NO_UNIT ? NO_UNIT : halve_to(best, k);
   endfunction

   function automatic bit coalesce_pass();
      int h, r, b;
      bit changed;
      h = 1 << heap_log2;
      r = 0;
      b = next_blk(0);
      changed = 1'b0;
      while (r < h && b < h) begin
         if (hdr_free[r & UMASK] && hdr_free[b & UMASK] && hsz(r) == hsz(b)) begin
            hdr_size[r & UMASK] = 4'(hsz(r) + 1);
            r = next_blk(r);
            if (r < h) b = next_blk(r);
            changed = 1'b1;
         end else if (hsz(r) > hsz(b)) begin
            r = b;
            b = next_blk(b);
         end else begin
            r = next_blk(b);
            if (r < h) b = next_blk(r);
         end
      end
      return changed;
   endfunction

   function automatic int grab_block(int k);
      int u;
      u = find_block(k);
      if (u == NO_UNIT) begin
         while (coalesce_pass());
         u = find_block(k);
      end
      if (u != NO_UNIT) hdr_free[u & UMASK] = 1'b0;
      return u;
   endfunction

   function automatic bit is_used_start(int u);
      int h, p;
      h = 1 << heap_log2;
      p = 0;
      if (u >= h) return 1'b0;
      while (p < h && p != u) p = next_blk(p);
      return p == u && !hdr_free[u & UMASK];
   endfunction

   function automatic logic [13:0] unit_offset(int u);
      return 14'((u + 1) * 16);
   endfunction

   function automatic void drop_live(int u);
      for (int i = live_q.size() - 1; i >= 0; i--) begin
         if (((int'(live_q[i] >> 4) + DEPTH - 1) & UMASK) == u) live_q.delete(i);
      end
   endfunction

   function automatic bha_rsp_type predict_heap(bha_req_type r);
      bha_rsp_type o;
      int u, k, n, total;
      o = '0;
      u = (int'(r.block_offset >> 4) + DEPTH - 1) & UMASK;
      total = int'(r.req_bytes) + 16;
      k = 0;
      while ((16 << k) < total) k++;
      if (r.req_type == REQ_FREE) begin
         if (r.has_block && is_used_start(u)) begin
            hdr_free[u] = 1'b1;
            drop_live(u);
         end
      end else if (r.req_type == REQ_ALLOC || (r.req_type == REQ_REALLOC && !r.has_block)) begin
         n = grab_block(k);
         if (n == NO_UNIT) o.status = 1'b1;
         else begin
            o.payload_offset = unit_offset(n);
            live_q.push_back(o.payload_offset);
         end
      end else if (r.req_type == REQ_REALLOC) begin
         if (!is_used_start(u)) o.status = 1'b1;
         else if (hsz(u) >= k) o.payload_offset = unit_offset(u);
         else begin
            n = grab_block(k);
            if (n == NO_UNIT) o.status = 1'b1;
            else begin
               o.payload_offset = unit_offset(n);
               o.copy_bytes = 14'(((1 << hsz(u)) - 1) * 16);
               hdr_free[u] = 1'b1;
               drop_live(u);
               live_q.push_back(o.payload_offset);
            end
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_q.size() == 0) report_mismatch("unexpected result", 1, 0);
         else begin
            if (rsp_data.status !== rsp_q[0].status)
               report_mismatch("status", rsp_data.status, rsp_q[0].status);
            if (rsp_data.payload_offset !== rsp_q[0].payload_offset)
               report_mismatch("payload_offset", rsp_data.payload_offset,
                               rsp_q[0].payload_offset);
            if (rsp_data.copy_bytes !== rsp_q[0].copy_bytes)
               report_mismatch("copy_bytes", rsp_data.copy_bytes, rsp_q[0].copy_bytes);
            void'(rsp_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic issue(bha_req_type r, bit typed, bha_rsp_type tv);
      bha_rsp_type p;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = predict_heap(r);
      rsp_q.push_back(typed ? tv : p);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
   endtask

   task automatic set_heap_size(logic [31:0] v);
      int c;
      start <= 1'b0;
      while (rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_HEAP_LOG2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      c = int'(v[3:0]);
      if (c < 1) c = 1;
      if (c > MAX_UNITS_LOG2) c = MAX_UNITS_LOG2;
      rebuild_heap(c);
      live_q.delete();
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_bytes();
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) return 16'($urandom);
      if (p < 25) return 16'($urandom_range(0, 1000));
      return 16'($urandom_range(0, 120));
   endfunction

   function automatic bha_req_type random_request();
      bha_req_type r;
      int p;
      p = $urandom_range(0, 99);
      r = '0;
      r.req_bytes = pick_bytes();
      if (p < 40) r.req_type = REQ_ALLOC;
      else if (p < 88 && live_q.size() != 0) begin
         r.req_type = p < 70 ? REQ_FREE : REQ_REALLOC;
         r.has_block = $urandom_range(0, 9) != 0;
         r.block_offset = live_q[$urandom_range(0, live_q.size() - 1)];
      end else begin
         r = bha_req_type'(($bits(bha_req_type))'({$urandom, $urandom}));
         r.req_bytes = 16'($urandom);
      end
      return r;
   endfunction

   row_type plan [$];
   bha_req_type rq;
   logic [31:0] sizes [6];

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      errors = 0;
      gap_pct = 36;
      idle_cycles = 0;
      rebuild_heap(MAX_UNITS_LOG2);
      plan = '{
         '{REQ_ALLOC,   16'd0,     1'b0, 14'd0,     1'b1, '0},
         '{REQ_FREE,    16'd0,     1'b1, 14'd0,     1'b1, '0},
         '{REQ_ALLOC,   16'hffff,  1'b0, 14'd0,     1'b1, bha_rsp_type'{1'b1, 14'd0, 14'd0}},
         '{REQ_NONE,    16'hffff,  1'b1, 14'h3fff,  1'b1, '0},
         '{REQ_FREE,    16'd0,     1'b0, 14'd16,    1'b1, '0},
         '{REQ_REALLOC, 16'd5,     1'b1, 14'h3fff,  1'b0, '0},
         '{REQ_ALLOC,   16'd1,     1'b0, 14'd0,     1'b0, '0},
         '{REQ_ALLOC,   16'd15,    1'b0, 14'd0,     1'b0, '0},
         '{REQ_ALLOC,   16'd16,    1'b0, 14'd0,     1'b0, '0},
         '{REQ_ALLOC,   16'd17,    1'b0, 14'd0,     1'b0, '0},
         '{REQ_ALLOC,   16'd1000,  1'b0, 14'd0,     1'b0, '0},
         '{REQ_REALLOC, 16'd50,    1'b0, 14'd0,     1'b0, '0},
         '{REQ_REALLOC, 16'd200,   1'b1, 14'd0,     1'b0, '0},
         '{REQ_REALLOC, 16'd0,     1'b1, 14'd0,     1'b0, '0},
         '{REQ_FREE,    16'd0,     1'b1, 14'h3fff,  1'b0, '0},
         '{REQ_ALLOC,   16'd16000, 1'b0, 14'd0,     1'b0, '0},
         '{REQ_ALLOC,   16'd16368, 1'b0, 14'd0,     1'b0, '0},
         '{REQ_REALLOC, 16'd20,    1'b1, 14'd5,     1'b0, '0}
      };
      sizes = '{32'd4, 32'd15, 32'd1, 32'd0, 32'd6, 32'd10};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (plan[i]) begin
         rq.req_type = plan[i].kind;
         rq.req_bytes = plan[i].bytes;
         rq.has_block = plan[i].has;
         rq.block_offset = plan[i].off;
         issue(rq, plan[i].typed, plan[i].rsp);
      end
      for (int seg = 0; seg < 6; seg++) begin
         gap_pct = seg < 2 ? 36 : (seg < 4 ? 66 : 0);
         set_heap_size(sizes[seg]);
         for (int n = 0; n < 180; n++) begin
            if (n == 90) begin
               start <= 1'b0;
               while (rsp_q.size() != 0) @(posedge clock);
            end
            issue(random_request(), 1'b0, '0);
         end
      end
      start <= 1'b0;
      while (rsp_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/bha_pkg.sv
src/bha_ram.sv
src/bha_ctrl.sv
src/buddy_heap_allocator.sv
bench/buddy_heap_allocator_test.sv
